[rtl/core/irn_pkg.sv]
// ============================================================================
// irn_pkg : shared types and constants for the image rotate nearest unit
// beat structs, frame geometry, fixed-point widths and register indexes
// ============================================================================
package irn_pkg;

    // frame geometry and fixed point
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 14;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W   = 24;
    localparam int ANGLE_W = 16;
    localparam int PIV_W   = 9;
    localparam int SIZE_W  = 10;
    localparam int DIFF_W  = PIV_W + 1;
    localparam int PROD_W  = DIFF_W + ANGLE_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CFG_IDX_W = 3;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

    // register reset values
    localparam logic signed [ANGLE_W-1:0] RST_COS_ANGLE = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] RST_SIN_ANGLE = 16'sd0;
    localparam logic [PIV_W-1:0]  RST_PIVOT_X      = 9'd256;
    localparam logic [PIV_W-1:0]  RST_PIVOT_Y      = 9'd256;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 10'd512;

    typedef struct packed {
        logic             command;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel_in;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             outside;
    } t_out_beat;

endpackage

[rtl/core/image_rotate_nearest_unit.sv]
// ============================================================================
// image_rotate_nearest_unit : rotated frame read-out by inverse mapping
// stores a source frame and returns nearest source pixels of a rotated view
// ============================================================================
// The unit holds a 512 x 512 source frame of 24-bit pixels in one synchronous
// memory (address row * 512 + col). A write beat stores one pixel and gives no
// output beat. A fetch beat names a destination pixel; the unit maps it back
// about the pivot with the programmed Q1.14 cosine and sine, truncates to whole
// pixels and returns the stored colour, or zero with outside set when the
// mapped point falls off the frame in use. One beat is taken every clock while
// o_in_stall is low; a fetch passes through products, sums and range check,
// memory read and output register on its way out. The memory's single write
// port and single read port sit in the same stage, so beats hit the frame in
// acceptance order and a fetch always sees every earlier write. The frame has
// no reset and no clearing pass: fetching a pixel never written returns
// undefined colour. Registers may be written only while no beat is in flight.
// ============================================================================
module image_rotate_nearest_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  irn_pkg::t_in_beat             i_in_beat,
    // output beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output irn_pkg::t_out_beat            o_out_beat,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import irn_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] r_cos, r_sin;
    logic [PIV_W-1:0]          r_pivot_x, r_pivot_y;
    logic [SIZE_W-1:0]         r_frame_w, r_frame_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos     <= RST_COS_ANGLE;
            r_sin     <= RST_SIN_ANGLE;
            r_pivot_x <= RST_PIVOT_X;
            r_pivot_y <= RST_PIVOT_Y;
            r_frame_w <= RST_FRAME_WIDTH;
            r_frame_h <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COS_ANGLE:    r_cos     <= $signed(i_cfg_data[ANGLE_W-1:0]);
                CFG_SIN_ANGLE:    r_sin     <= $signed(i_cfg_data[ANGLE_W-1:0]);
                CFG_PIVOT_X:      r_pivot_x <= i_cfg_data[PIV_W-1:0];
                CFG_PIVOT_Y:      r_pivot_y <= i_cfg_data[PIV_W-1:0];
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data[SIZE_W-1:0];
                default: ;  // indexes beyond the list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: each stage moves when it is empty or its successor
    // moves; write beats leave the memory stage without needing the
    // output register, so bubbles squeeze out
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    logic s3_is_write;

    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || s3_is_write || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3 && !s3_is_write;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: offsets from the pivot and the four rotation products
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [PROD_W-1:0] r_dx_cos, r_dy_sin, r_dy_cos, r_dx_sin;
    t_in_beat                 r_s1;

    assign dx = $signed({1'b0, i_in_beat.col}) - $signed({1'b0, r_pivot_x});
    assign dy = $signed({1'b0, i_in_beat.row}) - $signed({1'b0, r_pivot_y});

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1     <= i_in_beat;
            r_dx_cos <= dx * r_cos;
            r_dy_sin <= dy * r_sin;
            r_dy_cos <= dy * r_cos;
            r_dx_sin <= dx * r_sin;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: source point, range check, memory address
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] piv_x_fix, piv_y_fix, src_x, src_y, lim_x, lim_y;
    logic [SIZE_W-1:0]       w_sat, h_sat, w_m1, h_m1;
    logic                    off_frame;
    logic [ADDR_W-1:0]       s2_addr;

    assign piv_x_fix = $signed({{(SUM_W-PIV_W-FRAC_BITS){1'b0}}, r_pivot_x,
                                {FRAC_BITS{1'b0}}});
    assign piv_y_fix = $signed({{(SUM_W-PIV_W-FRAC_BITS){1'b0}}, r_pivot_y,
                                {FRAC_BITS{1'b0}}});

    assign src_x = SUM_W'(r_dx_cos) + SUM_W'(r_dy_sin) + piv_x_fix;
    assign src_y = SUM_W'(r_dy_cos) - SUM_W'(r_dx_sin) + piv_y_fix;

    // frame size saturates at the store size
    assign w_sat = (r_frame_w > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : r_frame_w;
    assign h_sat = (r_frame_h > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_frame_h;
    assign w_m1  = w_sat - SIZE_W'(1);
    assign h_m1  = h_sat - SIZE_W'(1);
    assign lim_x = $signed({{(SUM_W-SIZE_W-FRAC_BITS){1'b0}}, w_m1, {FRAC_BITS{1'b0}}});
    assign lim_y = $signed({{(SUM_W-SIZE_W-FRAC_BITS){1'b0}}, h_m1, {FRAC_BITS{1'b0}}});

    assign off_frame = (w_sat == '0) || (h_sat == '0) ||
                       src_x[SUM_W-1] || src_y[SUM_W-1] ||
                       (src_x > lim_x) || (src_y > lim_y);

    // writes address the named pixel, fetches the truncated source point
    assign s2_addr = (r_s1.command == CMD_WRITE) ? {r_s1.row, r_s1.col}
                   : {src_y[FRAC_BITS +: ROW_W], src_x[FRAC_BITS +: COL_W]};

    logic              r_s2_cmd;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [PIX_W-1:0]  r_s2_pix;
    logic              r_s2_outside;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_cmd     <= r_s1.command;
            r_s2_addr    <= s2_addr;
            r_s2_pix     <= r_s1.pixel_in;
            r_s2_outside <= off_frame;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: frame memory, one write port and one registered read port
    // ------------------------------------------------------------------
    logic              r_s3_cmd;
    logic [ADDR_W-1:0] r_s3_addr;
    logic [PIX_W-1:0]  r_s3_pix;
    logic              r_s3_outside;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_cmd     <= r_s2_cmd;
            r_s3_addr    <= r_s2_addr;
            r_s3_pix     <= r_s2_pix;
            r_s3_outside <= r_s2_outside;
        end
    end

    assign s3_is_write = (r_s3_cmd == CMD_WRITE);

    logic [PIX_W-1:0] r_frame_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             r_out_outside;

    always_ff @(posedge i_clk) begin
        if (r_v3 && s3_is_write) begin
            r_frame_mem[r_s3_addr] <= r_s3_pix;
        end
        if (en4) begin
            r_rd_data <= r_frame_mem[r_s3_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: output register, read data held while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en4) r_out_outside <= r_s3_outside;
    end

    assign o_out_valid          = r_v4;
    assign o_out_beat.pixel_out = r_out_outside ? '0 : r_rd_data;
    assign o_out_beat.outside   = r_out_outside;

`ifndef SYNTHESIS
    // input side stalls only behind a full pipe blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall))
        else $error("input stalled while the pipe can move");

    // a new output beat comes only from a fetch in the memory stage
    a_out_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v3 && (r_s3_cmd == CMD_FETCH)))
        else $error("output beat without a fetch behind it");

    // a write beat in the memory stage never waits
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && s3_is_write) |-> en3)
        else $error("write beat held in memory stage");
`endif

endmodule

[verif/irn_rotate_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// irn_rotate_checker : output checker for the image rotate nearest unit
// mirrors the source frame and registers, predicts every fetch and compares
// ============================================================================
module irn_rotate_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  irn_pkg::t_in_beat             i_in_beat,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  irn_pkg::t_out_beat            i_out_beat,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import irn_pkg::*;

    // shadow registers and frame
    logic signed [ANGLE_W-1:0] cos_q;
    logic signed [ANGLE_W-1:0] sin_q;
    logic [PIV_W-1:0]          piv_x;
    logic [PIV_W-1:0]          piv_y;
    logic [SIZE_W-1:0]         span_w;
    logic [SIZE_W-1:0]         span_h;
    logic [PIX_W-1:0]          frame_copy [0:DEPTH-1];

    t_out_beat rotated_due[$];
    int        fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // inverse rotation about the pivot, truncated to whole source pixels
    function automatic t_out_beat rotate_fetch(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        longint unit_len, wid, hgt, cosv, sinv, dx, dy, sx, sy;
        t_out_beat r;
        unit_len = longint'(1) << FRAC_BITS;
        wid  = (span_w > MAX_WIDTH) ? MAX_WIDTH : longint'(span_w);
        hgt  = (span_h > MAX_HEIGHT) ? MAX_HEIGHT : longint'(span_h);
        cosv = cos_q;
        sinv = sin_q;
        dx   = longint'(col) - longint'(piv_x);
        dy   = longint'(row) - longint'(piv_y);
        sx   = dx * cosv + dy * sinv + longint'(piv_x) * unit_len;
        sy   = dy * cosv - dx * sinv + longint'(piv_y) * unit_len;
        r.outside = (wid == 0) || (hgt == 0) || (sx < 0) || (sy < 0) ||
                    (sx > (wid - 1) * unit_len) || (sy > (hgt - 1) * unit_len);
        r.pixel_out = '0;
        if (!r.outside)
            r.pixel_out = frame_copy[(sy >>> FRAC_BITS) * MAX_WIDTH + (sx >>> FRAC_BITS)];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        bit        bad;
        if (!i_rst_n) begin
            cos_q  = RST_COS_ANGLE;
            sin_q  = RST_SIN_ANGLE;
            piv_x  = RST_PIVOT_X;
            piv_y  = RST_PIVOT_Y;
            span_w = RST_FRAME_WIDTH;
            span_h = RST_FRAME_HEIGHT;
            rotated_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COS_ANGLE:    cos_q  = i_cfg_data;
                    CFG_SIN_ANGLE:    sin_q  = i_cfg_data;
                    CFG_PIVOT_X:      piv_x  = i_cfg_data[PIV_W-1:0];
                    CFG_PIVOT_Y:      piv_y  = i_cfg_data[PIV_W-1:0];
                    CFG_FRAME_WIDTH:  span_w = i_cfg_data[SIZE_W-1:0];
                    CFG_FRAME_HEIGHT: span_h = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // results first: a fetch accepted now cannot answer in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (rotated_due.size() == 0) begin
                    $display("%0t: output beat with no fetch waiting, expected none, actual %06h/%0b",
                             $time, i_out_beat.pixel_out, i_out_beat.outside);
                    fails++;
                end else begin
                    want = rotated_due.pop_front();
                    bad  = 1'b0;
                    if (i_out_beat.pixel_out !== want.pixel_out) begin
                        $display("%0t: pixel_out expected %06h actual %06h",
                                 $time, want.pixel_out, i_out_beat.pixel_out);
                        bad = 1'b1;
                    end
                    if (i_out_beat.outside !== want.outside) begin
                        $display("%0t: outside expected %0b actual %0b",
                                 $time, want.outside, i_out_beat.outside);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_beat.command == CMD_WRITE)
                    frame_copy[i_in_beat.row * MAX_WIDTH + i_in_beat.col] = i_in_beat.pixel_in;
                else
                    rotated_due.push_back(rotate_fetch(i_in_beat.col, i_in_beat.row));
            end
        end
        o_pending    <= rotated_due.size();
        o_fail_count <= fails;
    end

endmodule

[verif/tb_image_rotate_nearest_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_image_rotate_nearest_unit : testbench for the image rotate nearest unit
// directed and randomized frame writes and rotated fetches under many settings
// ============================================================================
// The stimulus side writes source pixels and fetches rotated destination
// pixels, with random gaps on the input and random stalls on the output.
// Before each fetch whose source point lands inside the frame in use on a
// pixel never written, that pixel is written first, so no fetch can land on
// an undefined source pixel. The checker beside the unit predicts every fetch
// and counts mismatches.
// ============================================================================
module tb_image_rotate_nearest_unit;
    import irn_pkg::*;

    localparam int RUN_LIMIT     = 600_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_IDLE      = 12;
    localparam int RANDOM_SETS   = 12;
    localparam int SET_ITEMS     = 70;
    localparam real PI           = 3.14159265358979;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_beat             in_beat   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_beat            out_beat;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    logic idle_on       = 1'b1;    // random gaps and stalls enabled
    int   fail_count;
    int   pending_count;
    int   cycle_count   = 0;
    int   stall_left    = 0;
    int   n_writes      = 0;
    int   n_fetches     = 0;
    int   n_reg_writes  = 0;
    int   n_settings    = 0;
    bit   written [0:DEPTH-1];     // source pixels written so far

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    image_rotate_nearest_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    irn_rotate_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // output pacing: a random stall after each taken beat, and now and then
    // a stall while nothing is offered so it also lands ahead of a beat
    always @(posedge clk) begin : out_pacing
        int hold;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if ((out_valid && !out_stall) ||
                     (!out_valid && stall_left == 0 && $urandom_range(0, 15) == 0)) begin
            hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            stall_left <= hold;
            out_stall  <= (hold != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // one input beat: optional gap, then hold until taken
    task automatic push_beat(input t_in_beat b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (b.command == CMD_WRITE)
            n_writes++;
        else
            n_fetches++;
    endtask

    task automatic put_pixel(input int col, input int row, input logic [PIX_W-1:0] colour);
        t_in_beat b;
        b.command  = CMD_WRITE;
        b.col      = COL_W'(col);
        b.row      = ROW_W'(row);
        b.pixel_in = colour;
        written[row * MAX_WIDTH + col] = 1'b1;
        push_beat(b);
    endtask

    // the colour on a fetch beat is don't-care for the unit, callers pass junk
    task automatic fetch_pixel(input int col, input int row, input logic [PIX_W-1:0] junk);
        t_in_beat b;
        b.command  = CMD_FETCH;
        b.col      = COL_W'(col);
        b.row      = ROW_W'(row);
        b.pixel_in = junk;
        push_beat(b);
    endtask

    // source pixel of a destination under the given setting, and whether it
    // lies inside the frame in use
    function automatic bit maps_into_frame(input logic [15:0] cos_v, input logic [15:0] sin_v,
                                           input logic [15:0] px_v, input logic [15:0] py_v,
                                           input int span_c, input int span_r,
                                           input int col, input int row,
                                           output int sx, output int sy);
        longint unit_len, c, s, px, py, dx, dy, x, y;
        unit_len = longint'(1) << FRAC_BITS;
        c  = longint'($signed(cos_v));
        s  = longint'($signed(sin_v));
        px = longint'(px_v[PIV_W-1:0]);
        py = longint'(py_v[PIV_W-1:0]);
        dx = longint'(col) - px;
        dy = longint'(row) - py;
        x  = dx * c + dy * s + px * unit_len;
        y  = dy * c - dx * s + py * unit_len;
        sx = int'(x >>> FRAC_BITS);
        sy = int'(y >>> FRAC_BITS);
        return (span_c != 0) && (span_r != 0) && (x >= 0) && (y >= 0) &&
               (x <= longint'(span_c - 1) * unit_len) &&
               (y <= longint'(span_r - 1) * unit_len);
    endfunction

    // wait until every fetch has answered and the pipe has emptied
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // valid is left high between back-to-back writes, the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        n_reg_writes++;
    endtask

    // program one setting, then mixed traffic
    task automatic run_setting(input logic [15:0] cos_v, input logic [15:0] sin_v,
                               input logic [15:0] px_v, input logic [15:0] py_v,
                               input logic [15:0] w_v, input logic [15:0] h_v,
                               input int n_items, input bit quiet);
        int span_c, span_r, col_lim, row_lim, pick, col, row, sx, sy;
        settle();
        idle_on <= !quiet;
        write_reg(CFG_COS_ANGLE, cos_v);
        write_reg(CFG_SIN_ANGLE, sin_v);
        write_reg(CFG_PIVOT_X, px_v);
        write_reg(CFG_PIVOT_Y, py_v);
        write_reg(CFG_FRAME_WIDTH, w_v);
        write_reg(CFG_FRAME_HEIGHT, h_v);
        cfg_valid <= 1'b0;
        n_settings++;

        // sizes above the store saturate, zero means nothing is inside
        span_c = (w_v[SIZE_W-1:0] > MAX_WIDTH) ? MAX_WIDTH : int'(w_v[SIZE_W-1:0]);
        span_r = (h_v[SIZE_W-1:0] > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_v[SIZE_W-1:0]);

        // destinations mostly near the frame in use, some anywhere
        col_lim = (span_c + 3 > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : span_c + 3;
        row_lim = (span_r + 3 > MAX_HEIGHT - 1) ? MAX_HEIGHT - 1 : span_r + 3;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                col = ($urandom_range(0, 3) != 0) ? $urandom_range(0, col_lim)
                                                  : $urandom_range(0, MAX_WIDTH - 1);
                row = ($urandom_range(0, 3) != 0) ? $urandom_range(0, row_lim)
                                                  : $urandom_range(0, MAX_HEIGHT - 1);
                // a source pixel never written gets a colour just ahead of the fetch
                if (maps_into_frame(cos_v, sin_v, px_v, py_v, span_c, span_r,
                                    col, row, sx, sy) &&
                    !written[sy * MAX_WIDTH + sx])
                    put_pixel(sx, sy, PIX_W'($urandom));
                fetch_pixel(col, row, PIX_W'($urandom));
            end else if (pick < 95 && span_c != 0 && span_r != 0) begin
                put_pixel($urandom_range(0, span_c - 1), $urandom_range(0, span_r - 1),
                          PIX_W'($urandom));
            end else begin
                // writes beyond the frame in use are kept by the store
                put_pixel($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                          PIX_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        real         theta;
        logic [15:0] cos_v, sin_v, px_v, py_v, w_v, h_v;
        int          shape, w, h, px, py;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting is the identity map over the full store, so only
        // pixels written here are fetched: corners, all-ones and all-zero colour
        put_pixel(0, 0, 24'hFFFFFF);
        put_pixel(MAX_WIDTH - 1, MAX_HEIGHT - 1, 24'h000000);
        put_pixel(MAX_WIDTH - 1, 0, 24'h800001);
        put_pixel(0, MAX_HEIGHT - 1, 24'h7FFFFE);
        fetch_pixel(0, 0, 24'hFFFFFF);
        fetch_pixel(MAX_WIDTH - 1, MAX_HEIGHT - 1, 24'h000000);
        fetch_pixel(MAX_WIDTH - 1, 0, 24'hA5A5A5);
        fetch_pixel(0, MAX_HEIGHT - 1, 24'h5A5A5A);
        // write then fetch the same pixel back to back, then overwrite it
        put_pixel(5, 7, 24'h123456);
        fetch_pixel(5, 7, 24'h000000);
        put_pixel(5, 7, 24'hABCDEF);
        fetch_pixel(5, 7, 24'hFFFFFF);

        // half turn about an interior pivot
        run_setting(16'hC000, 16'h0000, 16'd6, 16'd5, 16'd12, 16'd10, 40, 1'b0);
        // zero width: every fetch lands outside
        run_setting(16'h4000, 16'h0000, 16'd3, 16'd2, 16'd0, 16'd5, 40, 1'b0);
        // zero height, quarter turn, no gaps or stalls
        run_setting(16'h0000, 16'h4000, 16'd0, 16'd0, 16'd7, 16'd0, 40, 1'b1);
        // width above the store saturates, single row
        run_setting(16'h4000, 16'h0000, 16'd256, 16'd0, 16'd1023, 16'd1, 40, 1'b0);
        // tallest frame, single column, half turn about the middle row
        run_setting(16'hC000, 16'h0000, 16'd0, 16'd256, 16'd1, 16'd512, 40, 1'b0);
        // angles beyond the unit circle
        run_setting(16'h8000, 16'h7FFF, 16'd8, 16'd8, 16'd16, 16'd16, 40, 1'b1);
        // upper register bits set: pivot column 511, width 16, height 20
        run_setting(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hFC10, 16'h0014, 40, 1'b0);

        repeat (RANDOM_SETS) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    theta = $urandom_range(0, 359);
                    theta = theta * PI / 180.0;
                    cos_v = 16'($rtoi($cos(theta) * 16384.0));
                    sin_v = 16'($rtoi($sin(theta) * 16384.0));
                end
                2: begin
                    cos_v = 16'(int'($urandom_range(0, 32768)) - 16384);
                    sin_v = 16'(int'($urandom_range(0, 32768)) - 16384);
                end
                default: begin
                    cos_v = 16'($urandom);
                    sin_v = 16'($urandom);
                end
            endcase
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                h = (w == 0) ? $urandom_range(0, 20) : 0;
            end else if (shape == 1) begin
                w = $urandom_range(512, 1023);
                h = 1;
            end else if (shape == 2) begin
                w = 1;
                h = $urandom_range(512, 1023);
            end else begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 20);
            end
            px = $urandom_range(0, ($urandom_range(0, 3) != 0) ? 24 : MAX_WIDTH - 1);
            py = $urandom_range(0, ($urandom_range(0, 3) != 0) ? 24 : MAX_HEIGHT - 1);
            // ignored upper bits carry junk now and then
            if ($urandom_range(0, 3) == 0) begin
                px_v = {7'($urandom), 9'(px)};
                py_v = {7'($urandom), 9'(py)};
                w_v  = {6'($urandom), 10'(w)};
                h_v  = {6'($urandom), 10'(h)};
            end else begin
                px_v = 16'(px);
                py_v = 16'(py);
                w_v  = 16'(w);
                h_v  = 16'(h);
            end
            run_setting(cos_v, sin_v, px_v, py_v, w_v, h_v, SET_ITEMS,
                        $urandom_range(0, 3) == 0);
        end

        settle();
        $display("covered %0d pixel writes and %0d rotated fetches", n_writes, n_fetches);
        $display("over %0d register settings (%0d register writes)", n_settings, n_reg_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
